### rtl/core/tmps_pkg.sv
`default_nettype none
package tmps_pkg;
	localparam int OUT_BITS = 22;
	localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
	localparam logic [1:0] REG_ROW_COUNT = 2'd0;

	typedef logic signed [OUT_BITS-1:0] sum_t;

	typedef struct packed {
		logic kind;
		sum_t value;
		logic last;
	} result_t;

	function automatic sum_t sat_add(input sum_t a, input sum_t b);
		logic signed [OUT_BITS:0] s;
		s = {a[OUT_BITS-1], a} + {b[OUT_BITS-1], b};
		if (s[OUT_BITS] != s[OUT_BITS-1]) begin
			sat_add = s[OUT_BITS] ? OUT_MIN : OUT_MAX;
		end else begin
			sat_add = s[OUT_BITS-1:0];
		end
	endfunction
endpackage
`default_nettype wire

### rtl/core/tmps_front.sv
`default_nettype none
module tmps_front
	import tmps_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int VALUE_BITS = 16,
	parameter int AW = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [15:0] cell_value,
	input wire logic [5:0] rows,
	input wire logic restart,
	input wire logic busy,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [VALUE_BITS-1:0] wr_data,
	output logic start
);
	localparam int RW = $clog2(MAX_ROWS + 1);
	logic [AW:0] count_q;
	logic [AW:0] total;
	logic [RW-1:0] n;
	logic [2*RW+1:0] prod;

	always_comb begin
		if (rows == 6'd0) begin
			n = RW'(1);
		end else if (32'(rows) > MAX_ROWS) begin
			n = RW'(MAX_ROWS);
		end else begin
			n = RW'(rows);
		end
		prod = (2*RW+2)'(n) * ((2*RW+2)'(n) + 1'b1);
		total = (AW+1)'(prod >> 1);
	end

	assign in_stall = busy;
	assign wr_en = in_valid && !busy;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = cell_value[VALUE_BITS-1:0];
	assign start = wr_en && (count_q + 1'b1 == total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (restart) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= start ? '0 : count_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

### rtl/core/tmps_back.sv
`default_nettype none
module tmps_back
	import tmps_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int VALUE_BITS = 16,
	parameter int AW = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [VALUE_BITS-1:0] wr_data,
	input wire logic start,
	input wire logic [5:0] rows,
	output logic busy,
	output logic out_valid,
	input wire logic out_stall,
	output result_t out_word
);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_RD = 3'd1, ST_WB = 3'd2,
		ST_SUM = 3'd3, ST_PRD = 3'd4, ST_PWB = 3'd5;

	logic [VALUE_BITS-1:0] tri_mem [DEPTH];
	logic go_mem [DEPTH];
	sum_t best_q [MAX_ROWS];
	logic [VALUE_BITS-1:0] rd_s1;
	logic go_s1;
	logic [2:0] st_q;
	logic [RW-1:0] n_q, row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] base_q, addr_q;
	logic leaf_q;
	result_t q_word [2];
	logic [1:0] q_cnt_q;
	logic q_rd_q, q_wr_q;
	logic push;
	result_t push_word;
	sum_t val_s;
	sum_t left, right;
	logic take_right;
	logic [RW-1:0] n_in;

	always_comb begin
		if (rows == 6'd0) begin
			n_in = RW'(1);
		end else if (32'(rows) > MAX_ROWS) begin
			n_in = RW'(MAX_ROWS);
		end else begin
			n_in = RW'(rows);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tri_mem[wr_addr] <= wr_data;
		end
		rd_s1 <= tri_mem[addr_q];
		go_s1 <= go_mem[addr_q];
		if (st_q == ST_WB && !leaf_q) begin
			go_mem[addr_q] <= take_right;
		end
	end

	assign val_s = OUT_BITS'($signed(rd_s1));
	assign left = best_q[col_q];
	assign right = best_q[(col_q == CW'(MAX_ROWS - 1)) ? col_q : col_q + 1'b1];
	assign take_right = !(left > right);
	assign busy = (st_q != ST_IDLE);

	always_comb begin
		push = 1'b0;
		push_word = '0;
		if (st_q == ST_SUM && q_cnt_q < 2'd2) begin
			push = 1'b1;
			push_word = '{kind: 1'b0, value: best_q[0], last: 1'b0};
		end else if (st_q == ST_PWB && q_cnt_q < 2'd2) begin
			push = 1'b1;
			push_word = '{kind: 1'b1, value: val_s, last: (row_q == n_q - 1'b1)};
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WB) begin
			best_q[col_q] <= leaf_q ? val_s
				: sat_add(val_s, take_right ? right : left);
		end
		if (push) begin
			q_word[q_wr_q] <= push_word;
		end
	end

	assign out_valid = q_cnt_q != 2'd0;
	assign out_word = q_word[q_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			n_q <= '0;
			row_q <= '0;
			col_q <= '0;
			base_q <= '0;
			addr_q <= '0;
			leaf_q <= 1'b0;
			q_cnt_q <= '0;
			q_rd_q <= 1'b0;
			q_wr_q <= 1'b0;
		end else begin
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(out_valid && !out_stall);
			if (push) q_wr_q <= !q_wr_q;
			if (out_valid && !out_stall) q_rd_q <= !q_rd_q;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						n_q <= n_in;
						row_q <= n_in - 1'b1;
						col_q <= '0;
						base_q <= AW'((32'(n_in) - 1) * 32'(n_in) / 2);
						addr_q <= AW'((32'(n_in) - 1) * 32'(n_in) / 2);
						leaf_q <= 1'b1;
						st_q <= ST_RD;
					end
				end
				ST_RD: st_q <= ST_WB;
				ST_WB: begin
					if (32'(col_q) < 32'(row_q)) begin
						col_q <= col_q + 1'b1;
						addr_q <= addr_q + 1'b1;
						st_q <= ST_RD;
					end else if (row_q == '0) begin
						st_q <= ST_SUM;
					end else begin
						row_q <= row_q - 1'b1;
						col_q <= '0;
						base_q <= base_q - AW'(row_q);
						addr_q <= base_q - AW'(row_q);
						leaf_q <= 1'b0;
						st_q <= ST_RD;
					end
				end
				ST_SUM: begin
					if (push) begin
						addr_q <= '0;
						base_q <= '0;
						row_q <= '0;
						st_q <= ST_PRD;
					end
				end
				ST_PRD: st_q <= ST_PWB;
				ST_PWB: begin
					if (push) begin
						if (row_q == n_q - 1'b1) begin
							st_q <= ST_IDLE;
						end else begin
							row_q <= row_q + 1'b1;
							base_q <= base_q + AW'(row_q) + 1'b1;
							addr_q <= addr_q + AW'(row_q) + 1'b1 + AW'(go_s1);
							st_q <= ST_PRD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/core/triangle_max_path_sum_core.sv
// Maximum path sum through a number triangle.
// The row count register (byte address 0) sets the rows of a triangle.
// Writing it drops any partly loaded triangle. Words on the input channel
// are the triangle entries in row-major order, one per cycle while loading.
// The word that completes the triangle starts the bottom-up pass, which
// visits each cell in a read state and then a write-back state, since the
// store has a single read port. Input is stalled during the pass and
// while the path is being emitted. The output channel then carries the sum
// word, followed by one word per row along the chosen path, the last one
// marked by last_item. A two-entry queue holds result words, so a stalled
// receiver only pauses the emission. Reset returns the block to loading
// with a row count of one. Stored entries hold no reset value.
`default_nettype none
module triangle_max_path_sum_core
	import tmps_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int VALUE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [0:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [15:0] cell_value,
	output logic out_valid,
	input wire logic out_stall,
	output logic item_kind,
	output logic [21:0] out_value,
	output logic last_item
);
	localparam int AW = $clog2(MAX_ROWS * (MAX_ROWS + 1) / 2 + 1);
	logic [5:0] rows_q;
	logic restart, busy, wr_en, start;
	logic [AW-1:0] wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	result_t word;

	assign pready = 1'b1;
	assign restart = psel && penable && pwrite && ({1'b0, paddr} == REG_ROW_COUNT);
	assign prdata = (paddr == 1'b0) ? {26'd0, rows_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 6'd1;
		end else if (restart) begin
			rows_q <= pwdata[5:0];
		end
	end

	tmps_front #(.MAX_ROWS(MAX_ROWS), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .cell_value, .rows(rows_q), .restart,
		.busy, .wr_en, .wr_addr, .wr_data, .start
	);

	tmps_back #(.MAX_ROWS(MAX_ROWS), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data, .start, .rows(rows_q), .busy,
		.out_valid, .out_stall, .out_word(word)
	);

	assign item_kind = word.kind;
	assign out_value = word.value;
	assign last_item = word.last;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en) else $error("input taken during pass");
	a_last_is_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_item |-> item_kind) else $error("last on sum word");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		u_back.q_cnt_q <= 2'd2) else $error("queue overflow");
endmodule
`default_nettype wire
